@@ hdl/srpc_pkg.sv @@
// ----------------------------------------------------------------------------
// srpc_pkg
// Shared constants, field widths and types for the SRRIP replacement block
// with a PC reuse predictor.
// ----------------------------------------------------------------------------
package srpc_pkg;

   // payload field widths
   localparam int unsigned SetIndexW  = 11;
   localparam int unsigned PcW        = 64;
   localparam int unsigned HitWayW    = 4;
   localparam int unsigned ChosenWayW = 4;
   localparam int unsigned NewRrpvW   = 2;
   localparam int unsigned ThresholdW = 2;

   // reuse counters
   localparam int unsigned CtrW = 2;
   localparam logic [ThresholdW-1:0] ThresholdReset = 2'd2;

   // parameter defaults
   localparam int unsigned DefNumSets     = 2048;
   localparam int unsigned DefNumWays     = 16;
   localparam int unsigned DefPredEntries = 4096;
   localparam int unsigned DefRrpvBits    = 2;

   // widest way number and RRPV over the allowed parameter range
   localparam int unsigned MaxWayW  = 5;
   localparam int unsigned MaxRrpvW = 4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_SCAN,
      ST_AGE,
      ST_TRAIN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic                has_invalid;
      logic [MaxWayW-1:0]  first_invalid;
      logic [MaxRrpvW-1:0] max_rrpv;
      logic [MaxWayW-1:0]  first_at_level;
   } scan_result_type;

endpackage

@@ hdl/srpc_channels.sv @@
// ----------------------------------------------------------------------------
// srpc channels
// Valid/ready channels of the replacement block: access request, result and
// threshold register write.
// ----------------------------------------------------------------------------
interface srpc_req_if import srpc_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [SetIndexW-1:0] set_index;
   logic [PcW-1:0]       pc;
   logic                 hit;
   logic [HitWayW-1:0]   hit_way;

   modport source (output valid, set_index, pc, hit, hit_way, input ready);
   modport sink   (input valid, set_index, pc, hit, hit_way, output ready);
endinterface

interface srpc_rsp_if import srpc_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [ChosenWayW-1:0] chosen_way;
   logic                  filled_empty;
   logic [NewRrpvW-1:0]   new_rrpv;

   modport source (output valid, chosen_way, filled_empty, new_rrpv, input ready);
   modport sink   (input valid, chosen_way, filled_empty, new_rrpv, output ready);
endinterface

interface srpc_csr_if import srpc_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [ThresholdW-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ hdl/srpc_const_mod.sv @@
// ----------------------------------------------------------------------------
// srpc_const_mod
// Remainder of a value by a constant modulus. A power-of-two modulus is a
// registered mask; any other modulus runs one restoring step per input
// bit.
// ----------------------------------------------------------------------------
module srpc_const_mod #(
   parameter  int unsigned IN_W    = 11,
   parameter  int unsigned MODULUS = 2048,
   localparam int unsigned RES_W   = (MODULUS > 1) ? $clog2(MODULUS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [IN_W-1:0]  value,
   output logic             busy,
   output logic [RES_W-1:0] result
);

   localparam bit IS_POW2 = ((MODULUS & (MODULUS - 1)) == 0);

   generate
      if (IS_POW2) begin : g_mask
         localparam int unsigned KEEP_W = (RES_W < IN_W) ? RES_W : IN_W;
         logic [RES_W-1:0] rem_ff;
         logic [RES_W-1:0] rem_in;

         assign rem_in = (MODULUS == 1) ? '0 : RES_W'(value[KEEP_W-1:0]);

         always_ff @(posedge clock) begin
            if (start) begin
               rem_ff <= rem_in;
            end
         end

         assign busy   = 1'b0;
         assign result = rem_ff;
      end else begin : g_serial
         localparam int unsigned CNT_W = $clog2(IN_W + 1);
         logic               busy_ff;
         logic [CNT_W-1:0]   cnt_ff;
         logic [IN_W-1:0]    shift_ff;
         logic [RES_W-1:0]   rem_ff;
         logic [RES_W:0]     cand;
         logic [RES_W:0]     step_rem;
         logic [RES_W-1:0]   rem_in;

         // shift in the next dividend bit, subtract the modulus if it fits
         assign cand     = {rem_ff, shift_ff[IN_W-1]};
         assign step_rem = (cand >= (RES_W + 1)'(MODULUS)) ?
                           cand - (RES_W + 1)'(MODULUS) : cand;
         assign rem_in   = step_rem[RES_W-1:0];

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               cnt_ff  <= '0;
            end else if (start) begin
               busy_ff <= 1'b1;
               cnt_ff  <= CNT_W'(IN_W);
            end else if (busy_ff) begin
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  busy_ff <= 1'b0;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               shift_ff <= value;
               rem_ff   <= '0;
            end else if (busy_ff) begin
               shift_ff <= {shift_ff[IN_W-2:0], 1'b0};
               rem_ff   <= rem_in;
            end
         end

         assign busy   = busy_ff;
         assign result = rem_ff;
      end
   endgenerate

endmodule

@@ hdl/srpc_row_scan.sv @@
// ----------------------------------------------------------------------------
// srpc_row_scan
// Looks over one set row: lowest invalid way, highest RRPV, lowest way at a
// given RRPV, and the row's RRPVs aged so that the given level reaches max.
// ----------------------------------------------------------------------------
module srpc_row_scan import srpc_pkg::*; #(
   parameter int unsigned NUM_WAYS  = DefNumWays,
   parameter int unsigned RRPV_BITS = DefRrpvBits
) (
   input  logic [NUM_WAYS-1:0]           valid_row,
   input  logic [NUM_WAYS*RRPV_BITS-1:0] rrpv_row,
   input  logic [RRPV_BITS-1:0]          level,
   output scan_result_type               result,
   output logic [NUM_WAYS*RRPV_BITS-1:0] aged_row
);

   localparam int unsigned LEVELS = 1 << RRPV_BITS;
   localparam logic [RRPV_BITS-1:0] RRPV_MAX = '1;

   logic [LEVELS-1:0]    present;
   logic [RRPV_BITS-1:0] lift;

   always_comb begin
      result  = '0;
      present = '0;
      // descending so the lowest matching way is the last one written
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (!valid_row[w]) begin
            result.has_invalid   = 1'b1;
            result.first_invalid = MaxWayW'(w);
         end
         if (rrpv_row[w*RRPV_BITS +: RRPV_BITS] == level) begin
            result.first_at_level = MaxWayW'(w);
         end
         present[rrpv_row[w*RRPV_BITS +: RRPV_BITS]] = 1'b1;
      end
      for (int v = 0; v < LEVELS; v++) begin
         if (present[v]) begin
            result.max_rrpv = MaxRrpvW'(v);
         end
      end
   end

   assign lift = RRPV_MAX - level;

   generate
      for (genvar w = 0; w < NUM_WAYS; w++) begin : g_age
         assign aged_row[w*RRPV_BITS +: RRPV_BITS] =
            rrpv_row[w*RRPV_BITS +: RRPV_BITS] + lift;
      end
   endgenerate

endmodule

@@ hdl/srrip_pc_reuse_replacement.sv @@
// ----------------------------------------------------------------------------
// srrip_pc_reuse_replacement
// SRRIP replacement for a set-associative cache, with insertion steered by a
// direct-mapped table of 2-bit PC reuse counters.
//
// req_ch carries one access (set, PC, hit flag, hit way); rsp_ch returns one
// result per access (chosen way, empty-fill flag, new RRPV). csr_ch writes
// the friendly threshold and is always ready.
// One access is worked at a time. Each set is one row of the row memory,
// read once and written back once; the counter table is a second memory.
// A miss that ages the set and trains a counter adds the counter read and its
// write-back. Moduli that are not powers of two make the reduction run one
// restoring step per input bit.
// After reset a clearing pass over max(NUM_SETS, PRED_ENTRIES) addresses
// (4096 by default) empties the sets and zeroes the counters; req_ch is
// not ready meanwhile. The result sits in an output register, so the next
// access is taken while rsp_ch stalls; only the write-back of that next
// access waits for the register to be free.
// ----------------------------------------------------------------------------
module srrip_pc_reuse_replacement import srpc_pkg::*; #(
   parameter int unsigned NUM_SETS     = DefNumSets,
   parameter int unsigned NUM_WAYS     = DefNumWays,
   parameter int unsigned PRED_ENTRIES = DefPredEntries,
   parameter int unsigned RRPV_BITS    = DefRrpvBits
) (
   input  logic              clock,
   input  logic              reset,
   srpc_req_if.sink          req_ch,
   srpc_rsp_if.source        rsp_ch,
   srpc_csr_if.sink          csr_ch
);

   localparam int unsigned SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int unsigned WAY_W     = $clog2(NUM_WAYS);
   localparam int unsigned SIG_W     = $clog2(PRED_ENTRIES);
   localparam int unsigned RB        = RRPV_BITS;
   localparam int unsigned SIG_LSB   = 0;
   localparam int unsigned RRPV_LSB  = NUM_WAYS * SIG_W;
   localparam int unsigned VALID_LSB = NUM_WAYS * (SIG_W + RB);
   localparam int unsigned ROW_W     = NUM_WAYS * (1 + RB + SIG_W);
   localparam int unsigned CLR_DEPTH = (NUM_SETS > PRED_ENTRIES) ? NUM_SETS : PRED_ENTRIES;
   localparam int unsigned CLR_W     = $clog2(CLR_DEPTH + 1);
   localparam int unsigned CW_KEEP   = (WAY_W < ChosenWayW) ? WAY_W : ChosenWayW;
   localparam int unsigned NR_KEEP   = (RB < NewRrpvW) ? RB : NewRrpvW;
   localparam logic [RB-1:0] RRPV_MAX = '1;

   // state
   state_type state_ff, state_in;
   logic [CLR_W-1:0]      clr_ff;
   logic [ThresholdW-1:0] thr_ff;
   logic                  hit_ff;
   logic [WAY_W-1:0]      way_ff;
   logic                  empty_ff;
   logic [RB-1:0]         max_lvl_ff;
   logic [NUM_WAYS*RB-1:0] rrpv_work_ff;
   logic [SIG_W-1:0]      vic_sig_ff;
   logic [CtrW-1:0]       trained_ff;
   logic                  fwd_ff;
   logic                  rsp_valid_ff;
   logic [ChosenWayW-1:0] rsp_way_ff;
   logic                  rsp_empty_ff;
   logic [NewRrpvW-1:0]   rsp_rrpv_ff;

   // memories
   logic [ROW_W-1:0] row_mem [NUM_SETS];
   logic [CtrW-1:0]  ctr_mem [PRED_ENTRIES];
   logic [ROW_W-1:0] row_rd_ff;
   logic [CtrW-1:0]  ctr_rd_ff;

   logic             row_re, row_we;
   logic [SET_W-1:0] row_waddr;
   logic [ROW_W-1:0] row_wdata;
   logic             ctr_re, ctr_we;
   logic [SIG_W-1:0] ctr_raddr, ctr_waddr;
   logic [CtrW-1:0]  ctr_wdata;

   // reduced request fields
   logic             req_xfer;
   logic             set_busy, sig_busy, way_busy;
   logic [SET_W-1:0] set_res;
   logic [SIG_W-1:0] sig_res;
   logic [WAY_W-1:0] hway_res;

   // row views and scan
   logic [NUM_WAYS-1:0]       row_valid;
   logic [NUM_WAYS*RB-1:0]    row_rrpv;
   logic [NUM_WAYS*SIG_W-1:0] row_sig;
   scan_result_type           scan;
   logic [NUM_WAYS*RB-1:0]    aged_row;
   logic [WAY_W-1:0]          vic_way;

   // write-back
   logic                      out_free;
   logic [CtrW-1:0]           ctr_val;
   logic [CtrW-1:0]           ctr_dec;
   logic [RB-1:0]             newr;
   logic [NUM_WAYS-1:0]       wr_valid;
   logic [NUM_WAYS*RB-1:0]    wr_rrpv;
   logic [NUM_WAYS*SIG_W-1:0] wr_sig;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   srpc_const_mod #(.IN_W(SetIndexW), .MODULUS(NUM_SETS)) u_set_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (req_xfer),
      .value  (req_ch.set_index),
      .busy   (set_busy),
      .result (set_res)
   );

   srpc_const_mod #(.IN_W(PcW), .MODULUS(PRED_ENTRIES)) u_sig_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (req_xfer),
      .value  (req_ch.pc),
      .busy   (sig_busy),
      .result (sig_res)
   );

   srpc_const_mod #(.IN_W(HitWayW), .MODULUS(NUM_WAYS)) u_way_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (req_xfer),
      .value  (req_ch.hit_way),
      .busy   (way_busy),
      .result (hway_res)
   );

   assign row_valid = row_rd_ff[VALID_LSB +: NUM_WAYS];
   assign row_rrpv  = row_rd_ff[RRPV_LSB +: NUM_WAYS*RB];
   assign row_sig   = row_rd_ff[SIG_LSB +: NUM_WAYS*SIG_W];

   srpc_row_scan #(.NUM_WAYS(NUM_WAYS), .RRPV_BITS(RRPV_BITS)) u_scan (
      .valid_row (row_valid),
      .rrpv_row  (row_rrpv),
      .level     (max_lvl_ff),
      .result    (scan),
      .aged_row  (aged_row)
   );

   assign vic_way = scan.first_at_level[WAY_W-1:0];

   // the victim of an aged set always sits at max RRPV, so training counts down
   assign ctr_dec = (ctr_rd_ff == '0) ? '0 : ctr_rd_ff - CtrW'(1);
   assign ctr_val = fwd_ff ? trained_ff : ctr_rd_ff;
   assign newr    = (hit_ff || (ctr_val >= thr_ff)) ? '0 : RRPV_MAX;

   always_comb begin
      wr_valid = row_valid;
      wr_rrpv  = rrpv_work_ff;
      wr_sig   = row_sig;
      wr_valid[way_ff]             = 1'b1;
      wr_rrpv[way_ff*RB +: RB]     = newr;
      wr_sig[way_ff*SIG_W +: SIG_W] = sig_res;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_W'(CLR_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (!set_busy && !sig_busy && !way_busy) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit_ff || scan.has_invalid) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_AGE;
            end
         end
         ST_AGE:   state_in = ST_TRAIN;
         ST_TRAIN: state_in = ST_WRITE;
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory and handshake controls
   always_comb begin
      req_ch.ready = 1'b0;
      row_re       = 1'b0;
      row_we       = 1'b0;
      row_waddr    = set_res;
      row_wdata    = {wr_valid, wr_rrpv, wr_sig};
      ctr_re       = 1'b0;
      ctr_raddr    = sig_res;
      ctr_we       = 1'b0;
      ctr_waddr    = vic_sig_ff;
      ctr_wdata    = ctr_dec;
      unique case (state_ff)
         ST_CLEAR: begin
            row_we    = (clr_ff < CLR_W'(NUM_SETS));
            row_waddr = clr_ff[SET_W-1:0];
            row_wdata = {{NUM_WAYS{1'b0}}, {(NUM_WAYS*RB){1'b1}},
                         {(NUM_WAYS*SIG_W){1'b0}}};
            ctr_we    = (clr_ff < CLR_W'(PRED_ENTRIES));
            ctr_waddr = clr_ff[SIG_W-1:0];
            ctr_wdata = '0;
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_REDUCE: begin
            row_re = !set_busy && !sig_busy && !way_busy;
         end
         ST_SCAN: begin
            ctr_re = !hit_ff && scan.has_invalid;
         end
         ST_AGE: begin
            ctr_re    = 1'b1;
            ctr_raddr = row_sig[vic_way*SIG_W +: SIG_W];
         end
         ST_TRAIN: begin
            ctr_we = 1'b1;
            ctr_re = 1'b1;
         end
         ST_WRITE: begin
            row_we = out_free;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      if (row_re) begin
         row_rd_ff <= row_mem[set_res];
      end
   end

   always_ff @(posedge clock) begin
      if (ctr_we) begin
         ctr_mem[ctr_waddr] <= ctr_wdata;
      end
      if (ctr_re) begin
         ctr_rd_ff <= ctr_mem[ctr_raddr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         thr_ff       <= ThresholdReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + CLR_W'(1);
         end
         if (csr_ch.valid) begin
            thr_ff <= csr_ch.data;
         end
         if (state_ff == ST_WRITE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers of the access in flight
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               hit_ff <= req_ch.hit;
               fwd_ff <= 1'b0;
            end
         end
         ST_SCAN: begin
            rrpv_work_ff <= row_rrpv;
            max_lvl_ff   <= scan.max_rrpv[RB-1:0];
            empty_ff     <= !hit_ff && scan.has_invalid;
            way_ff       <= hit_ff ? hway_res : scan.first_invalid[WAY_W-1:0];
         end
         ST_AGE: begin
            rrpv_work_ff <= aged_row;
            way_ff       <= vic_way;
            vic_sig_ff   <= row_sig[vic_way*SIG_W +: SIG_W];
         end
         ST_TRAIN: begin
            trained_ff <= ctr_dec;
            // the new PC may share the counter just trained
            fwd_ff     <= (vic_sig_ff == sig_res);
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_way_ff   <= ChosenWayW'(way_ff[CW_KEEP-1:0]);
               rsp_empty_ff <= empty_ff;
               rsp_rrpv_ff  <= NewRrpvW'(newr[NR_KEEP-1:0]);
            end
         end
         default: begin
            fwd_ff <= fwd_ff;
         end
      endcase
   end

   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.chosen_way   = rsp_way_ff;
   assign rsp_ch.filled_empty = rsp_empty_ff;
   assign rsp_ch.new_rrpv     = rsp_rrpv_ff;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SRRIP replacement block with a PC reuse
// predictor. A directed table (fills, hits on empty ways, field extremes,
// set ageing) is followed by random phases, each with a new friendly
// threshold. A per-access model of sets and reuse counters predicts each
// untyped result. Both channels idle at random, and the result side stalls
// once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_top;
   import srpc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NumSets     = DefNumSets;
   localparam int unsigned NumWays     = DefNumWays;
   localparam int unsigned PredEntries = DefPredEntries;
   localparam int unsigned NumLines    = NumSets * NumWays;
   localparam int unsigned SigW        = $clog2(DefPredEntries);
   localparam int unsigned RrpvW       = DefRrpvBits;
   localparam bit [RrpvW-1:0] RrpvMax  = '1;
   localparam bit [CtrW-1:0]  CtrMax   = '1;

   localparam int unsigned NumPhases     = 6;
   localparam int unsigned ItemsPerPhase = 240;
   localparam int unsigned HoldAfter     = 700;
   localparam int unsigned HoldCycles    = 400;
   localparam int unsigned WatchdogLimit = 20000;
   localparam int unsigned ReportLimit   = 10;

   typedef struct packed {
      logic [SetIndexW-1:0] set_index;
      logic [PcW-1:0]       pc;
      logic                 hit;
      logic [HitWayW-1:0]   hit_way;
   } access_t;

   typedef struct packed {
      logic [ChosenWayW-1:0] chosen_way;
      logic                  filled_empty;
      logic [NewRrpvW-1:0]   new_rrpv;
   } outcome_t;

   typedef struct {
      access_t  acc;
      bit       typed;
      outcome_t want;
   } row_t;

   logic clock;
   logic reset;

   srpc_req_if req_ch ();
   srpc_rsp_if rsp_ch ();
   srpc_csr_if csr_ch ();

   srrip_pc_reuse_replacement i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // model state
   bit [RrpvW-1:0]      line_rrpv  [NumLines];
   bit                  line_valid [NumLines];
   bit [SigW-1:0]       line_sig   [NumLines];
   bit [CtrW-1:0]       reuse_ctr  [PredEntries];
   bit [ThresholdW-1:0] threshold_q;

   outcome_t             pending_outcomes[$];
   row_t                 directed_rows[$];
   logic [SetIndexW-1:0] hot_sets[4];
   int unsigned          accepted_items;
   int unsigned          mismatches;
   bit                   no_idle;
   bit                   stall_done;

   localparam bit [ThresholdW-1:0] PhaseThreshold [NumPhases] = '{3, 0, 1, 3, 0, 2};

   initial begin
      clock = 1'b0;
      forever begin
         #1 clock = 1'b1;
         #1 clock = 1'b0;
      end
   end

   // one access through the set and counter model
   function automatic outcome_t srrip_update(access_t a);
      int unsigned   base;
      int unsigned   way;
      int unsigned   w;
      bit [RrpvW-1:0] top;
      bit [RrpvW-1:0] lift;
      bit [SigW-1:0] sig;
      bit [SigW-1:0] victim_sig;
      outcome_t      o;
      base = (int'(a.set_index) % NumSets) * NumWays;
      sig  = a.pc[SigW-1:0];   // table size is a power of two
      o    = '0;
      if (a.hit) begin
         way = int'(a.hit_way) % NumWays;
         o.new_rrpv = '0;
      end else begin
         way = NumWays;
         for (w = NumWays; w > 0; w--) begin
            if (!line_valid[base + w - 1]) way = w - 1;
         end
         if (way < NumWays) begin
            o.filled_empty = 1'b1;
         end else begin
            top = '0;
            for (w = 0; w < NumWays; w++) begin
               if (line_rrpv[base + w] > top) top = line_rrpv[base + w];
            end
            lift = RrpvMax - top;
            for (w = 0; w < NumWays; w++) line_rrpv[base + w] += lift;
            way = 0;
            for (w = NumWays; w > 0; w--) begin
               if (line_rrpv[base + w - 1] == RrpvMax) way = w - 1;
            end
            victim_sig = line_sig[base + way];
            if (line_rrpv[base + way] == '0) begin
               if (reuse_ctr[victim_sig] < CtrMax) reuse_ctr[victim_sig]++;
            end else if (reuse_ctr[victim_sig] > 0) begin
               reuse_ctr[victim_sig]--;
            end
         end
         o.new_rrpv = (reuse_ctr[sig] >= threshold_q) ? '0 : RrpvMax;
      end
      line_rrpv[base + way]  = o.new_rrpv;
      line_valid[base + way] = 1'b1;
      line_sig[base + way]   = sig;
      o.chosen_way = way[ChosenWayW-1:0];
      return o;
   endfunction

   // mostly short gaps, a few long ones, none at all in busy phases
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic access_t random_access();
      access_t a;
      a.pc      = {$urandom, $urandom};
      a.hit_way = $urandom_range(0, NumWays - 1);
      if ($urandom_range(0, 99) < 80) begin
         // hot sets fill up quickly, so most misses age and evict
         a.set_index = hot_sets[$urandom_range(0, 3)];
         a.hit       = ($urandom_range(0, 99) < 55);
      end else begin
         a.set_index = $urandom_range(0, NumSets - 1);
         a.hit       = $urandom_range(0, 1);
      end
      return a;
   endfunction

   function automatic void add_row(access_t acc, bit typed, outcome_t want);
      row_t r;
      r.acc   = acc;
      r.typed = typed;
      r.want  = want;
      directed_rows.push_back(r);
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= ReportLimit) $display("%s", what);
   endtask

   task automatic offer_access(access_t acc, bit typed, outcome_t want);
      int unsigned gap;
      outcome_t    model_out;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.set_index <= acc.set_index;
      req_ch.pc        <= acc.pc;
      req_ch.hit       <= acc.hit;
      req_ch.hit_way   <= acc.hit_way;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      model_out = srrip_update(acc);
      pending_outcomes.push_back(typed ? want : model_out);
      accepted_items++;
   endtask

   // drain all results, then give the write-back time to finish
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_threshold(bit [ThresholdW-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      threshold_q = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // stimulus
   initial begin
      int unsigned i;
      int unsigned p;
      access_t     acc;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.set_index = '0;
      req_ch.pc        = '0;
      req_ch.hit       = 1'b0;
      req_ch.hit_way   = '0;
      csr_ch.valid     = 1'b0;
      csr_ch.data      = '0;
      no_idle          = 1'b0;
      accepted_items   = 0;
      for (i = 0; i < NumLines; i++) begin
         line_rrpv[i]  = RrpvMax;
         line_valid[i] = 1'b0;
         line_sig[i]   = '0;
      end
      for (i = 0; i < PredEntries; i++) reuse_ctr[i] = '0;
      threshold_q = ThresholdReset;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // miss into an empty set, field extremes, hit on an invalid way
      add_row('{set_index: '0, pc: '0, hit: 1'b0, hit_way: '0}, 1'b1,
              '{chosen_way: 0, filled_empty: 1'b1, new_rrpv: RrpvMax});
      add_row('{set_index: '1, pc: '1, hit: 1'b1, hit_way: '1}, 1'b1,
              '{chosen_way: '1, filled_empty: 1'b0, new_rrpv: '0});
      add_row('{set_index: '1, pc: '1, hit: 1'b0, hit_way: '1}, 1'b1,
              '{chosen_way: 0, filled_empty: 1'b1, new_rrpv: RrpvMax});
      add_row('{set_index: '0, pc: 64'h8000_0000_0000_0000, hit: 1'b1, hit_way: '0}, 1'b1,
              '{chosen_way: 0, filled_empty: 1'b0, new_rrpv: '0});
      // fill one set, refresh a way, then force ageing and eviction training
      for (i = 0; i < NumWays; i++) begin
         acc = '{set_index: 3, pc: 64'h100 + i, hit: 1'b0, hit_way: '1};
         add_row(acc, 1'b0, '0);
      end
      add_row('{set_index: 3, pc: 64'h109, hit: 1'b1, hit_way: 9}, 1'b0, '0);
      add_row('{set_index: 3, pc: 64'hABC, hit: 1'b0, hit_way: 5}, 1'b0, '0);
      add_row('{set_index: 3, pc: 64'h100, hit: 1'b0, hit_way: 0}, 1'b0, '0);

      foreach (directed_rows[k])
         offer_access(directed_rows[k].acc, directed_rows[k].typed, directed_rows[k].want);
      settle();

      for (p = 0; p < NumPhases; p++) begin
         write_threshold(PhaseThreshold[p]);
         foreach (hot_sets[k]) hot_sets[k] = $urandom_range(0, NumSets - 1);
         no_idle = (p % 3 == 1);
         repeat (ItemsPerPhase) offer_access(random_access(), 1'b0, '0);
         settle();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // result side readiness, with one long hold-off
   initial begin
      int unsigned n;
      rsp_ch.ready = 1'b0;
      stall_done   = 1'b0;
      forever begin
         @(negedge clock);
         if (!stall_done && accepted_items >= HoldAfter) begin
            stall_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HoldCycles - 1) @(negedge clock);
         end else begin
            n = pick_gap();
            if (n == 0) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_ch.ready <= 1'b0;
               repeat (n - 1) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      outcome_t got;
      outcome_t want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = '{chosen_way: rsp_ch.chosen_way, filled_empty: rsp_ch.filled_empty,
                 new_rrpv: rsp_ch.new_rrpv};
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("unexpected result way=%0d empty=%0d rrpv=%0d",
                                      got.chosen_way, got.filled_empty, got.new_rrpv));
         end else begin
            want = pending_outcomes.pop_front();
            if (got.chosen_way !== want.chosen_way || got.filled_empty !== want.filled_empty
                || got.new_rrpv !== want.new_rrpv)
               report_mismatch($sformatf(
                  "result mismatch: way exp %0d got %0d, empty exp %0d got %0d, rrpv exp %0d got %0d",
                  want.chosen_way, got.chosen_way, want.filled_empty, got.filled_empty,
                  want.new_rrpv, got.new_rrpv));
         end
      end
   end

   // ends the run when no transfer happens for too long
   initial begin
      int unsigned idle_run;
      idle_run = 0;
      while (idle_run < WatchdogLimit) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
             || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
             || (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1))
            idle_run = 0;
         else
            idle_run++;
      end
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
